// ----- hdl/ntst_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest-target steering tracker package
// Shared types, register map codes, steering bit positions and the per-axis
// steering function used by the tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ntst_pkg;

   // Widths of the scaled coordinate domain and of the squared distance.
   localparam int unsigned CoordWidth = 14;
   localparam int unsigned ParamWidth = 12;
   localparam int unsigned DistWidth  = 30;

   // Scale register code that selects doubling; every other code means one.
   localparam logic [1:0] SCALE_DOUBLE = 2'd2;

   // Positions of the steering bits in a result beat.
   localparam int unsigned BIT_UP      = 0;
   localparam int unsigned BIT_DOWN    = 1;
   localparam int unsigned BIT_LEFT    = 2;
   localparam int unsigned BIT_RIGHT   = 3;
   localparam int unsigned BIT_ADVANCE = 4;
   localparam int unsigned BIT_BACK    = 5;

   // Register map: word index of each configuration register.
   typedef enum logic [2:0] {
      REG_CENTER_X    = 3'd0,
      REG_CENTER_Y    = 3'd1,
      REG_CENTER_SIZE = 3'd2,
      REG_BAND_XY     = 3'd3,
      REG_BAND_SIZE   = 3'd4,
      REG_STILL_XY    = 3'd5,
      REG_STILL_SIZE  = 3'd6,
      REG_SCALE       = 3'd7
   } reg_index_type;

   // Steering of one axis. Bit 0 is the low-side move, bit 1 the high-side.
   // Movement beyond the still threshold wins, and then only toward the
   // side of the center line the target is on; otherwise the dead band
   // around the center line decides.
   function automatic logic [1:0] axis_bits(
      input logic [CoordWidth-1:0] cur,
      input logic [CoordWidth-1:0] prev,
      input logic [CoordWidth-1:0] ctr,
      input logic [ParamWidth-1:0] band,
      input logic [ParamWidth-1:0] still
   );
      logic signed [15:0] cur_s;
      logic signed [15:0] ctr_s;
      logic signed [15:0] delta;
      logic signed [15:0] still_s;
      logic signed [15:0] band_s;
      logic [1:0]         bits;
      cur_s   = $signed({2'b00, cur});
      ctr_s   = $signed({2'b00, ctr});
      delta   = cur_s - $signed({2'b00, prev});
      still_s = $signed({4'b0000, still});
      band_s  = $signed({4'b0000, band});
      bits    = 2'b00;
      if (delta < -still_s) begin
         bits[0] = (cur_s < ctr_s);
      end else if (delta > still_s) begin
         bits[1] = (cur_s >= ctr_s);
      end else if (cur_s < ctr_s - band_s) begin
         bits[0] = 1'b1;
      end else if (cur_s > ctr_s + band_s) begin
         bits[1] = 1'b1;
      end
      return bits;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/nearest_target_steering_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// Nearest-target steering tracker
// Takes detection rectangles one beat at a time, keeps the one nearest the
// tracked center in each frame and emits six steering bits per frame.
// ----------------------------------------------------------------------------
// Path: each beat is taken into the input register; a beat that ends a frame
// then moves its result into the result register once that register is free.
// Throughput: one input beat per cycle; the input register and the result
// register are parted, so the channel only stalls when a result waits.
// The whole item is handled by the logic between the input register and the
// result register (scale, two 15-bit squares, add, compare, steering).
// Reset: synchronous; configuration returns to defaults and tracking stops.
`default_nettype none

module nearest_target_steering_tracker_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_empty_frame,
   input  wire logic [11:0] req_rect_x,
   input  wire logic [11:0] req_rect_y,
   input  wire logic [11:0] req_rect_w,
   input  wire logic [11:0] req_rect_h,
   input  wire logic        req_last_in_frame,
   // Result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [5:0]       rsp_turn_bits,
   output logic             rsp_no_face,
   // Configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // Configuration registers.
   logic [13:0] center_x_ff, center_y_ff, center_size_ff;
   logic [11:0] band_xy_ff, band_size_ff, still_xy_ff, still_size_ff;
   logic [1:0]  scale_ff;

   // Input register.
   logic        s1_valid_ff;
   logic        s1_empty_ff;
   logic [11:0] s1_rect_x_ff, s1_rect_y_ff, s1_rect_w_ff, s1_rect_h_ff;
   logic        s1_last_ff;

   // Tracking state.
   logic        track_valid_ff;
   logic        frame_started_ff;
   logic        frame_was_unarmed_ff;
   logic [13:0] prev_center_x_ff, prev_center_y_ff, prev_size_ff;
   logic [29:0] best_distance_ff;
   logic [13:0] best_center_x_ff, best_center_y_ff, best_size_ff;

   // Result register.
   logic        rsp_valid_ff;
   logic [5:0]  rsp_turn_bits_ff;
   logic        rsp_no_face_ff;

   // Processing signals.
   logic        s1_produces;
   logic        out_free;
   logic        s1_advance;
   logic        factor_two;
   logic [12:0] half_x, half_y;
   logic [13:0] cur_x, cur_y, cur_size;
   logic signed [14:0] delta_x, delta_y;
   logic signed [29:0] square_x, square_y;
   logic [29:0] distance;
   logic        first_item;
   logic        unarmed;
   logic        take;
   logic [13:0] best_x_in, best_y_in, best_size_in;
   logic [1:0]  steer_x, steer_y, steer_size;
   logic [5:0]  turn_in;

   // Configuration access.
   logic                   csr_write;
   ntst_pkg::reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = ntst_pkg::reg_index_type'(csr_paddr[4:2]);

   // Register write decode.
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= 14'd320;
         center_y_ff    <= 14'd240;
         center_size_ff <= 14'd140;
         band_xy_ff     <= 12'd35;
         band_size_ff   <= 12'd30;
         still_xy_ff    <= 12'd10;
         still_size_ff  <= 12'd15;
         scale_ff       <= ntst_pkg::SCALE_DOUBLE;
      end else if (csr_write) begin
         unique case (csr_index)
            ntst_pkg::REG_CENTER_X:    center_x_ff    <= csr_pwdata[13:0];
            ntst_pkg::REG_CENTER_Y:    center_y_ff    <= csr_pwdata[13:0];
            ntst_pkg::REG_CENTER_SIZE: center_size_ff <= csr_pwdata[13:0];
            ntst_pkg::REG_BAND_XY:     band_xy_ff     <= csr_pwdata[11:0];
            ntst_pkg::REG_BAND_SIZE:   band_size_ff   <= csr_pwdata[11:0];
            ntst_pkg::REG_STILL_XY:    still_xy_ff    <= csr_pwdata[11:0];
            ntst_pkg::REG_STILL_SIZE:  still_size_ff  <= csr_pwdata[11:0];
            ntst_pkg::REG_SCALE:       scale_ff       <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   // Register read mux.
   always_comb begin
      unique case (csr_index)
         ntst_pkg::REG_CENTER_X:    csr_prdata = {18'd0, center_x_ff};
         ntst_pkg::REG_CENTER_Y:    csr_prdata = {18'd0, center_y_ff};
         ntst_pkg::REG_CENTER_SIZE: csr_prdata = {18'd0, center_size_ff};
         ntst_pkg::REG_BAND_XY:     csr_prdata = {20'd0, band_xy_ff};
         ntst_pkg::REG_BAND_SIZE:   csr_prdata = {20'd0, band_size_ff};
         ntst_pkg::REG_STILL_XY:    csr_prdata = {20'd0, still_xy_ff};
         ntst_pkg::REG_STILL_SIZE:  csr_prdata = {20'd0, still_size_ff};
         ntst_pkg::REG_SCALE:       csr_prdata = {30'd0, scale_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // Flow control: the input register drains when its beat makes no result
   // or when the result register is free or being emptied.
   assign s1_produces = s1_empty_ff || s1_last_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign s1_advance  = s1_valid_ff && (!s1_produces || out_free);
   assign req_ready   = !s1_valid_ff || s1_advance;

   // Scaled center and size of the detection.
   assign factor_two = (scale_ff == ntst_pkg::SCALE_DOUBLE);
   assign half_x     = {1'b0, s1_rect_x_ff} + {2'b00, s1_rect_w_ff[11:1]};
   assign half_y     = {1'b0, s1_rect_y_ff} + {2'b00, s1_rect_h_ff[11:1]};
   assign cur_x      = factor_two ? {half_x, 1'b0} : {1'b0, half_x};
   assign cur_y      = factor_two ? {half_y, 1'b0} : {1'b0, half_y};
   assign cur_size   = factor_two ? {1'b0, s1_rect_w_ff, 1'b0} : {2'b00, s1_rect_w_ff};

   // Squared distance from the tracked center.
   assign delta_x  = $signed({1'b0, cur_x}) - $signed({1'b0, prev_center_x_ff});
   assign delta_y  = $signed({1'b0, cur_y}) - $signed({1'b0, prev_center_y_ff});
   assign square_x = delta_x * delta_x;
   assign square_y = delta_y * delta_y;
   assign distance = $unsigned(square_x) + $unsigned(square_y);

   // Frame bookkeeping. The first detection of a tracked frame always wins;
   // later ones win only when strictly nearer.
   assign first_item = !frame_started_ff;
   assign unarmed    = first_item ? !track_valid_ff : frame_was_unarmed_ff;
   assign take       = !unarmed && (first_item || (distance < best_distance_ff));

   assign best_x_in    = take ? cur_x    : best_center_x_ff;
   assign best_y_in    = take ? cur_y    : best_center_y_ff;
   assign best_size_in = take ? cur_size : best_size_ff;

   // Steering from the frame's best detection against the tracked target.
   assign steer_x    = ntst_pkg::axis_bits(best_x_in, prev_center_x_ff, center_x_ff,
                                           band_xy_ff, still_xy_ff);
   assign steer_y    = ntst_pkg::axis_bits(best_y_in, prev_center_y_ff, center_y_ff,
                                           band_xy_ff, still_xy_ff);
   assign steer_size = ntst_pkg::axis_bits(best_size_in, prev_size_ff, center_size_ff,
                                           band_size_ff, still_size_ff);

   always_comb begin
      turn_in = 6'd0;
      if (!s1_empty_ff && !unarmed) begin
         turn_in[ntst_pkg::BIT_UP]      = steer_y[0];
         turn_in[ntst_pkg::BIT_DOWN]    = steer_y[1];
         turn_in[ntst_pkg::BIT_LEFT]    = steer_x[0];
         turn_in[ntst_pkg::BIT_RIGHT]   = steer_x[1];
         turn_in[ntst_pkg::BIT_ADVANCE] = steer_size[0];
         turn_in[ntst_pkg::BIT_BACK]    = steer_size[1];
      end
   end

   // Input register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_empty_ff  <= req_empty_frame;
         s1_rect_x_ff <= req_rect_x;
         s1_rect_y_ff <= req_rect_y;
         s1_rect_w_ff <= req_rect_w;
         s1_rect_h_ff <= req_rect_h;
         s1_last_ff   <= req_last_in_frame;
      end
   end

   // Frame and tracking control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         track_valid_ff       <= 1'b0;
         frame_started_ff     <= 1'b0;
         frame_was_unarmed_ff <= 1'b0;
      end else if (s1_advance) begin
         if (s1_empty_ff || s1_last_ff) begin
            frame_started_ff     <= 1'b0;
            frame_was_unarmed_ff <= 1'b0;
         end else begin
            frame_started_ff     <= 1'b1;
            frame_was_unarmed_ff <= unarmed;
         end
         if (!s1_empty_ff && unarmed && first_item && s1_last_ff) begin
            track_valid_ff <= 1'b1;
         end
      end
   end

   // Best detection and tracked target.
   always_ff @(posedge clock) begin
      if (s1_advance && !s1_empty_ff) begin
         if (take) begin
            best_distance_ff <= distance;
            best_center_x_ff <= cur_x;
            best_center_y_ff <= cur_y;
            best_size_ff     <= cur_size;
         end
         if (unarmed && first_item && s1_last_ff) begin
            prev_center_x_ff <= cur_x;
            prev_center_y_ff <= cur_y;
            prev_size_ff     <= cur_size;
         end else if (!unarmed && s1_last_ff) begin
            prev_center_x_ff <= best_x_in;
            prev_center_y_ff <= best_y_in;
            prev_size_ff     <= best_size_in;
         end
      end
   end

   // Result register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_produces) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (s1_advance && s1_produces) begin
         rsp_turn_bits_ff <= turn_in;
         rsp_no_face_ff   <= s1_empty_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_turn_bits = rsp_turn_bits_ff;
   assign rsp_no_face   = rsp_no_face_ff;

   // An empty-frame beat never carries steering bits.
   a_no_face_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_no_face_ff |-> rsp_turn_bits_ff == 6'd0)
      else $error("no-face result carries steering bits");

   // Each axis moves at most one way.
   a_axis_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_turn_bits_ff[0] && rsp_turn_bits_ff[1]) &&
                       !(rsp_turn_bits_ff[2] && rsp_turn_bits_ff[3]) &&
                       !(rsp_turn_bits_ff[4] && rsp_turn_bits_ff[5]))
      else $error("opposite steering bits set together");

   // The unarmed mark only lives inside a started frame.
   a_unarmed_in_frame: assert property (@(posedge clock) disable iff (reset)
      frame_was_unarmed_ff |-> frame_started_ff)
      else $error("unarmed mark outside a frame");

   // A result beat never overwrites one still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !(s1_advance && s1_produces))
      else $error("result overwritten while stalled");

   // Tracking never stops once started.
   a_track_sticky: assert property (@(posedge clock) disable iff (reset)
      track_valid_ff |=> track_valid_ff)
      else $error("tracking dropped without reset");

endmodule

`default_nettype wire
